// ----- rtl/core/nrbs_pkg.sv -----
// Shared types and constants for the nearest room bounds search block.
package nrbs_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned EntryW = 4 * CoordW;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned RoomsCfgW = 7;
  localparam int unsigned SlotW = 6;
  localparam int unsigned KindW = 2;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_ROOMS_IN_USE = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_NO_ROOM_BOTTOM = 2'd1;

  localparam logic signed [CoordW-1:0] NO_ROOM_BOTTOM_RESET = 16'sd9999;

  localparam logic [KindW-1:0] KIND_SPAN = 2'd0;
  localparam logic [KindW-1:0] KIND_NEAREST = 2'd1;
  localparam logic [KindW-1:0] KIND_NONE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } nrbs_state_e;

  typedef struct packed {
    logic start;
    logic wr_en;
    logic rd_en;
    logic load_out;
  } nrbs_cmd_t;

endpackage

// ----- rtl/core/nrbs_ctrl.sv -----
// Controller: accepts words, sequences the table walk and the result register.
module nrbs_ctrl
  import nrbs_pkg::*;
#(
  parameter int unsigned AW = 6,
  parameter int unsigned CW = 7
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          action_i,
  input  logic [CW-1:0] count_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  logic          busy_i,
  output nrbs_cmd_t     cmd_o,
  output logic [AW-1:0] rd_addr_o
);

  nrbs_state_e   state_q, state_d;
  logic [AW-1:0] addr_q, addr_d;
  logic          out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      addr_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (action_i == ACT_WRITE) begin
            cmd_o.wr_en = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            addr_d      = '0;
            state_d     = (count_i == '0) ? ST_FINISH : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd_o.rd_en = 1'b1;
        if (addr_q == AW'(count_i - CW'(1))) begin
          state_d = ST_DRAIN;
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (!busy_i) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign rd_addr_o   = addr_q;
  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/core/nrbs_datapath.sv -----
// Datapath: room table, two-stage compare pipeline, best picks and result register.
module nrbs_datapath
  import nrbs_pkg::*;
#(
  parameter int unsigned MAX_ROOMS = 64,
  parameter int unsigned AW = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  nrbs_cmd_t                cmd_i,
  input  logic [AW-1:0]            rd_addr_i,
  input  logic [SlotW-1:0]         room_slot_i,
  input  logic signed [CoordW-1:0] rect_left_i,
  input  logic signed [CoordW-1:0] rect_top_i,
  input  logic signed [CoordW-1:0] rect_right_i,
  input  logic signed [CoordW-1:0] rect_bottom_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic signed [CoordW-1:0] no_room_bottom_i,
  output logic                     busy_o,
  output logic signed [CoordW-1:0] out_left_o,
  output logic signed [CoordW-1:0] out_top_o,
  output logic signed [CoordW-1:0] out_right_o,
  output logic signed [CoordW-1:0] out_bottom_o,
  output logic [KindW-1:0]         match_kind_o
);

  logic [EntryW-1:0] mem_q [MAX_ROOMS];
  logic [EntryW-1:0] rd_q, ent2_q, p1_best_q, p2_best_q;
  logic              v1_q, v2_q, p1_hit_q, p2_vld_q;
  logic signed [CoordW-1:0] px_q, py_q;
  logic [2*CoordW-1:0] sqx_q, sqy_q;
  logic [2*CoordW:0]   p2_d_q;
  logic signed [CoordW-1:0] out_left_q, out_top_q, out_right_q, out_bottom_q;
  logic [KindW-1:0]    kind_q;

  logic slot_ok;
  assign slot_ok = 32'(room_slot_i) < 32'(MAX_ROOMS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && slot_ok) begin
      mem_q[AW'(room_slot_i)] <= {rect_left_i, rect_top_i, rect_right_i, rect_bottom_i};
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // stage one: span test, bottom distance, clamped offsets and their squares
  logic signed [CoordW-1:0] r_l, r_t, r_r, r_b, best_b, cx, cy;
  logic signed [CoordW:0]   dby, dbb, dx, dy;
  logic [CoordW:0]          abs_by, abs_bb;
  logic [CoordW-1:0]        adx, ady;
  logic [2*CoordW-1:0]      sqx_d, sqy_d;
  logic                     p1_take;

  always_comb begin
    r_l    = rd_q[4*CoordW-1:3*CoordW];
    r_t    = rd_q[3*CoordW-1:2*CoordW];
    r_r    = rd_q[2*CoordW-1:CoordW];
    r_b    = rd_q[CoordW-1:0];
    best_b = p1_best_q[CoordW-1:0];
    dby    = {py_q[CoordW-1], py_q} - {r_b[CoordW-1], r_b};
    dbb    = {py_q[CoordW-1], py_q} - {best_b[CoordW-1], best_b};
    abs_by = dby[CoordW] ? (CoordW+1)'(-dby) : (CoordW+1)'(dby);
    abs_bb = dbb[CoordW] ? (CoordW+1)'(-dbb) : (CoordW+1)'(dbb);
    p1_take = v1_q && (r_l <= px_q) && (px_q <= r_r) && (abs_by < abs_bb);
    if (px_q < r_l) begin
      cx = r_l;
    end else if (px_q > r_r) begin
      cx = r_r;
    end else begin
      cx = px_q;
    end
    if (py_q < r_t) begin
      cy = r_t;
    end else if (py_q > r_b) begin
      cy = r_b;
    end else begin
      cy = py_q;
    end
    dx    = {px_q[CoordW-1], px_q} - {cx[CoordW-1], cx};
    dy    = {py_q[CoordW-1], py_q} - {cy[CoordW-1], cy};
    adx   = dx[CoordW] ? CoordW'(-dx) : CoordW'(dx);
    ady   = dy[CoordW] ? CoordW'(-dy) : CoordW'(dy);
    sqx_d = {{CoordW{1'b0}}, adx} * {{CoordW{1'b0}}, adx};
    sqy_d = {{CoordW{1'b0}}, ady} * {{CoordW{1'b0}}, ady};
  end

  // stage two: squared distance compare
  logic [2*CoordW:0] d_sum;
  logic              p2_take;
  assign d_sum   = {1'b0, sqx_q} + {1'b0, sqy_q};
  assign p2_take = v2_q && (!p2_vld_q || (d_sum < p2_d_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      p1_hit_q <= 1'b0;
      p2_vld_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.rd_en;
      v2_q <= v1_q;
      if (cmd_i.start) begin
        p1_hit_q <= 1'b0;
        p2_vld_q <= 1'b0;
      end else begin
        if (p1_take) p1_hit_q <= 1'b1;
        if (p2_take) p2_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sqx_q  <= sqx_d;
    sqy_q  <= sqy_d;
    ent2_q <= rd_q;
    if (cmd_i.start) begin
      px_q      <= point_x_i;
      py_q      <= point_y_i;
      p1_best_q <= {rect_left_i, rect_top_i, rect_right_i, no_room_bottom_i};
    end else if (p1_take) begin
      p1_best_q <= rd_q;
    end
    if (p2_take) begin
      p2_best_q <= ent2_q;
      p2_d_q    <= d_sum;
    end
  end

  // result register
  logic [EntryW-1:0] res;
  logic [KindW-1:0]  kind_d;
  always_comb begin
    if (!p2_vld_q) begin
      res    = p1_best_q;
      kind_d = KIND_NONE;
    end else if (p1_hit_q) begin
      res    = p1_best_q;
      kind_d = KIND_SPAN;
    end else begin
      res    = p2_best_q;
      kind_d = KIND_NEAREST;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_left_q   <= res[4*CoordW-1:3*CoordW];
      out_top_q    <= res[3*CoordW-1:2*CoordW];
      out_right_q  <= res[2*CoordW-1:CoordW];
      out_bottom_q <= res[CoordW-1:0];
      kind_q       <= kind_d;
    end
  end

  assign busy_o       = v1_q || v2_q;
  assign out_left_o   = out_left_q;
  assign out_top_o    = out_top_q;
  assign out_right_o  = out_right_q;
  assign out_bottom_o = out_bottom_q;
  assign match_kind_o = kind_q;

endmodule

// ----- rtl/core/nearest_room_bounds_search_top.sv -----
// Top level: configuration registers, controller and datapath of the room search.
//
// Input channel (in_valid_i / in_stall_o) carries one word per item. A write
// word (action 0) stores a room rectangle at room_slot_i and gives no result.
// A query word (action 1) walks table entries 0 to n-1, n being rooms_in_use
// limited to MAX_ROOMS, one entry a cycle through the single table read port,
// and gives one result word on the output channel (out_valid_o / out_stall_i).
// The input stalls while a query is being worked on. A finished result is
// held in the output register while the receiver stalls; the next word is
// accepted meanwhile, and a following query waits only to hand over its own
// result. Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i
// and is expected only while the block is idle. Reset clears the control
// state, sets rooms_in_use to 0 and no_room_bottom to 9999; the table holds
// nothing defined until entries are written.
module nearest_room_bounds_search_top
  import nrbs_pkg::*;
#(
  parameter int unsigned MAX_ROOMS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     action_i,
  input  logic [SlotW-1:0]         room_slot_i,
  input  logic signed [CoordW-1:0] rect_left_i,
  input  logic signed [CoordW-1:0] rect_top_i,
  input  logic signed [CoordW-1:0] rect_right_i,
  input  logic signed [CoordW-1:0] rect_bottom_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CoordW-1:0] out_left_o,
  output logic signed [CoordW-1:0] out_top_o,
  output logic signed [CoordW-1:0] out_right_o,
  output logic signed [CoordW-1:0] out_bottom_o,
  output logic [KindW-1:0]         match_kind_o
);

  localparam int unsigned AW = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ROOMS + 1);
  localparam int unsigned EW = (CW > RoomsCfgW) ? CW : RoomsCfgW;

  logic [RoomsCfgW-1:0]     rooms_q;
  logic signed [CoordW-1:0] sentinel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rooms_q    <= '0;
      sentinel_q <= NO_ROOM_BOTTOM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROOMS_IN_USE:   rooms_q    <= cfg_data_i[RoomsCfgW-1:0];
        CFG_NO_ROOM_BOTTOM: sentinel_q <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  logic [EW-1:0] rooms_ext;
  logic [CW-1:0] count;
  assign rooms_ext = EW'(rooms_q);
  assign count     = (rooms_ext > EW'(MAX_ROOMS)) ? CW'(MAX_ROOMS) : CW'(rooms_ext);

  nrbs_cmd_t     cmd;
  logic [AW-1:0] rd_addr;
  logic          busy;

  nrbs_ctrl #(
    .AW(AW),
    .CW(CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .count_i    (count),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .busy_i     (busy),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  nrbs_datapath #(
    .MAX_ROOMS(MAX_ROOMS),
    .AW       (AW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .rd_addr_i       (rd_addr),
    .room_slot_i     (room_slot_i),
    .rect_left_i     (rect_left_i),
    .rect_top_i      (rect_top_i),
    .rect_right_i    (rect_right_i),
    .rect_bottom_i   (rect_bottom_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .no_room_bottom_i(sentinel_q),
    .busy_o          (busy),
    .out_left_o      (out_left_o),
    .out_top_o       (out_top_o),
    .out_right_o     (out_right_o),
    .out_bottom_o    (out_bottom_o),
    .match_kind_o    (match_kind_o)
  );

endmodule

// ----- tb/nrbs_checker.sv -----
// Checker for the room bounds search: mirrors the table and registers, predicts and compares.
module nrbs_checker
  import nrbs_pkg::*;
#(
  parameter int unsigned MAX_ROOMS = 64
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CfgIdxW-1:0]       cfg_idx_i,
  input  logic [CfgDataW-1:0]      cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic                     action_i,
  input  logic [SlotW-1:0]         room_slot_i,
  input  logic signed [CoordW-1:0] rect_left_i,
  input  logic signed [CoordW-1:0] rect_top_i,
  input  logic signed [CoordW-1:0] rect_right_i,
  input  logic signed [CoordW-1:0] rect_bottom_i,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [CoordW-1:0] out_left_i,
  input  logic signed [CoordW-1:0] out_top_i,
  input  logic signed [CoordW-1:0] out_right_i,
  input  logic signed [CoordW-1:0] out_bottom_i,
  input  logic [KindW-1:0]         match_kind_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o,
  output int unsigned              checked_o
);

  typedef struct packed {
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] right;
    logic [CoordW-1:0] bottom;
  } room_t;

  typedef struct packed {
    room_t            rect;
    logic [KindW-1:0] kind;
  } bounds_t;

  room_t                room_copy [MAX_ROOMS];
  logic [RoomsCfgW-1:0] rooms_in_use;
  logic [CoordW-1:0]    no_room_bottom;
  bounds_t              bounds_due [$];
  int unsigned          mismatches;
  int unsigned          checked;

  function automatic longint wide(input logic [CoordW-1:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint abs_gap(input longint a, input longint b);
    return (a < b) ? b - a : a - b;
  endfunction

  // offset of v from its clamped value; low edge tested first
  function automatic longint clamp_gap(input longint v, input longint lo, input longint hi);
    if (v < lo) return v - lo;
    if (v > hi) return v - hi;
    return 0;
  endfunction

  function automatic bounds_t nearest_bounds(input logic [CoordW-1:0] prev_left,
                                             input logic [CoordW-1:0] prev_top,
                                             input logic [CoordW-1:0] prev_right,
                                             input logic [CoordW-1:0] px,
                                             input logic [CoordW-1:0] py);
    int unsigned n;
    longint      best;
    longint      d;
    longint      dx;
    longint      dy;
    bounds_t     res;
    n = (rooms_in_use > MAX_ROOMS) ? MAX_ROOMS : int'(rooms_in_use);
    res.rect.left   = prev_left;
    res.rect.top    = prev_top;
    res.rect.right  = prev_right;
    res.rect.bottom = no_room_bottom;
    for (int unsigned i = 0; i < n; i++) begin
      if (wide(room_copy[i].left) <= wide(px) && wide(px) <= wide(room_copy[i].right) &&
          abs_gap(wide(py), wide(room_copy[i].bottom)) <
          abs_gap(wide(py), wide(res.rect.bottom)))
        res.rect = room_copy[i];
    end
    if (n == 0) begin
      res.kind = KIND_NONE;
    end else if (res.rect.bottom != no_room_bottom) begin
      res.kind = KIND_SPAN;
    end else begin
      res.kind = KIND_NEAREST;
      best = 64'h7FFF_FFFF_FFFF_FFFF;
      for (int unsigned i = 0; i < n; i++) begin
        dx = clamp_gap(wide(px), wide(room_copy[i].left), wide(room_copy[i].right));
        dy = clamp_gap(wide(py), wide(room_copy[i].top), wide(room_copy[i].bottom));
        d = dx * dx + dy * dy;
        if (d < best) begin
          best = d;
          res.rect = room_copy[i];
        end
      end
    end
    return res;
  endfunction

  task automatic check_field(input string field, input int expv, input int actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", field, expv, actv);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bounds_t due;
    if (!rst_ni) begin
      rooms_in_use = '0;
      no_room_bottom = NO_ROOM_BOTTOM_RESET;
      bounds_due.delete();
      mismatches = 0;
      checked = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ROOMS_IN_USE: rooms_in_use = cfg_data_i[RoomsCfgW-1:0];
          CFG_NO_ROOM_BOTTOM: no_room_bottom = cfg_data_i[CoordW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (action_i == ACT_WRITE) begin
          room_copy[room_slot_i] = {rect_left_i, rect_top_i, rect_right_i, rect_bottom_i};
        end else begin
          bounds_due.push_back(nearest_bounds(rect_left_i, rect_top_i, rect_right_i,
                                              point_x_i, point_y_i));
        end
      end
      if (out_valid_i && !out_stall_i) begin
        if (bounds_due.size() == 0) begin
          $error("bounds word received with none outstanding");
          mismatches++;
        end else begin
          due = bounds_due.pop_front();
          checked++;
          check_field("out_left", $signed(due.rect.left), out_left_i);
          check_field("out_top", $signed(due.rect.top), out_top_i);
          check_field("out_right", $signed(due.rect.right), out_right_i);
          check_field("out_bottom", $signed(due.rect.bottom), out_bottom_i);
          check_field("match_kind", due.kind, match_kind_i);
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o <= bounds_due.size();
    checked_o <= checked;
  end

endmodule

// ----- tb/nearest_room_bounds_search_top_tb.sv -----
// Testbench top: clock, reset, stimulus and verdict for the room bounds search.
module nearest_room_bounds_search_top_tb;
  import nrbs_pkg::*;

  localparam int unsigned MaxRooms = 64;
  localparam int unsigned SettleCycles = MaxRooms + 16;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned DrainLimit = 20000;
  localparam int unsigned PhaseWords = 155;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_STALL,
    IDLE_BOTH
  } idling_e;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx = '0;
  logic [CfgDataW-1:0]      cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     action = ACT_WRITE;
  logic [SlotW-1:0]         room_slot = '0;
  logic signed [CoordW-1:0] rect_left = '0;
  logic signed [CoordW-1:0] rect_top = '0;
  logic signed [CoordW-1:0] rect_right = '0;
  logic signed [CoordW-1:0] rect_bottom = '0;
  logic signed [CoordW-1:0] point_x = '0;
  logic signed [CoordW-1:0] point_y = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [CoordW-1:0] out_left;
  logic signed [CoordW-1:0] out_top;
  logic signed [CoordW-1:0] out_right;
  logic signed [CoordW-1:0] out_bottom;
  logic [KindW-1:0]         match_kind;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned checked;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  int unsigned words_sent = 0;
  int unsigned phases = 0;
  logic        pressure_hold = 1'b0;
  logic        hold_taken = 1'b0;
  logic        drain_stuck = 1'b0;

  always #5 clk = ~clk;

  nearest_room_bounds_search_top #(
    .MAX_ROOMS(MaxRooms)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .room_slot_i  (room_slot),
    .rect_left_i  (rect_left),
    .rect_top_i   (rect_top),
    .rect_right_i (rect_right),
    .rect_bottom_i(rect_bottom),
    .point_x_i    (point_x),
    .point_y_i    (point_y),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_left_o   (out_left),
    .out_top_o    (out_top),
    .out_right_o  (out_right),
    .out_bottom_o (out_bottom),
    .match_kind_o (match_kind)
  );

  nrbs_checker #(
    .MAX_ROOMS(MaxRooms)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .action_i     (action),
    .room_slot_i  (room_slot),
    .rect_left_i  (rect_left),
    .rect_top_i   (rect_top),
    .rect_right_i (rect_right),
    .rect_bottom_i(rect_bottom),
    .point_x_i    (point_x),
    .point_y_i    (point_y),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_left_i   (out_left),
    .out_top_i    (out_top),
    .out_right_i  (out_right),
    .out_bottom_i (out_bottom),
    .match_kind_i (match_kind),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  // receiver: one long hold when asked, random stalls otherwise
  always @(posedge clk) begin
    if (pressure_hold && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [CoordW-1:0] rand_coord();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) return CoordW'($urandom_range(16) - 8);
    if (pick < 55) return CoordW'($urandom_range(400) - 200);
    if (pick < 85) return CoordW'($urandom);
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h8001;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4: return 16'h7FFE;
      default: return 16'h7FFF;
    endcase
  endfunction

  task automatic send_word(input logic act, input logic [SlotW-1:0] slot,
                           input logic [CoordW-1:0] l, input logic [CoordW-1:0] t,
                           input logic [CoordW-1:0] r, input logic [CoordW-1:0] b,
                           input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    room_slot <= slot;
    rect_left <= l;
    rect_top <= t;
    rect_right <= r;
    rect_bottom <= b;
    point_x <= x;
    point_y <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic room(input int slot, input int l, input int t, input int r, input int b);
    send_word(ACT_WRITE, SlotW'(slot), CoordW'(l), CoordW'(t), CoordW'(r), CoordW'(b),
              rand_coord(), rand_coord());
  endtask

  task automatic query(input int l, input int t, input int r, input int x, input int y);
    send_word(ACT_QUERY, SlotW'($urandom_range(63)), CoordW'(l), CoordW'(t), CoordW'(r),
              rand_coord(), CoordW'(x), CoordW'(y));
  endtask

  // mostly ordered edges, some inverted
  task automatic make_room(output logic [CoordW-1:0] l, output logic [CoordW-1:0] t,
                           output logic [CoordW-1:0] r, output logic [CoordW-1:0] b);
    l = rand_coord();
    t = rand_coord();
    r = rand_coord();
    b = rand_coord();
    if ($urandom_range(99) < 85 && $signed(l) > $signed(r)) {l, r} = {r, l};
    if ($urandom_range(99) < 85 && $signed(t) > $signed(b)) {t, b} = {b, t};
  endtask

  task automatic random_word();
    logic [CoordW-1:0] l, t, r, b;
    make_room(l, t, r, b);
    send_word(($urandom_range(99) < 40) ? ACT_WRITE : ACT_QUERY, SlotW'($urandom_range(63)),
              l, t, r, b, rand_coord(), rand_coord());
  endtask

  // wait for every bounds word, then for any room write still in flight
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_regs(input int rooms, input int bottom, input logic spare);
    cfg_we <= 1'b1;
    if (spare) begin
      cfg_idx <= CFG_SPARE_A;
      cfg_data <= 16'h0001;
      @(posedge clk);
      cfg_idx <= CFG_SPARE_B;
      cfg_data <= 16'h8000;
      @(posedge clk);
    end
    cfg_idx <= CFG_ROOMS_IN_USE;
    cfg_data <= CfgDataW'(rooms);
    @(posedge clk);
    cfg_idx <= CFG_NO_ROOM_BOTTOM;
    cfg_data <= CfgDataW'(bottom);
    @(posedge clk);
    cfg_we <= 1'b0;
    phases++;
  endtask

  task automatic set_idling(input idling_e mode);
    send_idle_pct = (mode == IDLE_SEND) ? 68 : (mode == IDLE_BOTH) ? 18 : 0;
    stall_pct <= (mode == IDLE_STALL) ? 68 : (mode == IDLE_BOTH) ? 18 : 0;
  endtask

  task automatic run_phase(input int rooms, input int bottom, input idling_e mode,
                           input int unsigned words, input logic squeeze);
    settle();
    write_regs(rooms, bottom, 1'b0);
    set_idling(mode);
    if (squeeze) pressure_hold <= 1'b1;
    repeat (words) random_word();
  endtask

  initial begin : stimulus
    logic [CoordW-1:0] l, t, r, b;
    int unsigned waited;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table
    query(-32768, 32767, -32768, 0, 0);
    query(32767, -32768, 32767, -32768, 32767);
    settle();
    write_regs(0, -32768, 1'b1);
    query(0, 0, 0, 32767, -32768);

    // spanning, inverted, whole-plane, duplicate and distant rooms
    room(0, -10, -20, 10, 5);
    room(1, 20, 0, 10, 8);
    room(2, -32768, -32768, 32767, 32767);
    room(3, -10, -20, 10, 5);
    room(4, 100, 50, 200, 70);
    settle();
    write_regs(5, 9999, 1'b0);
    query(-32768, -32768, 32767, 0, 4);
    query(1, 2, 3, 150, 60);
    query(1, 2, 3, 15, 0);
    query(7, 7, 7, -32768, -32768);
    query(7, 7, 7, 32767, 32767);

    // sentinel equal to a room bottom forces the fallback
    settle();
    write_regs(5, 5, 1'b0);
    query(0, 0, 0, 0, 4);
    query(0, 0, 0, 0, 100);
    settle();
    write_regs(1, 32767, 1'b0);
    query(-1, -1, -1, -10, -32768);
    query(-1, -1, -1, 11, 5);

    // fill the whole table
    settle();
    write_regs(5, 9999, 1'b0);
    set_idling(IDLE_BOTH);
    for (int s = 0; s < MaxRooms; s++) begin
      make_room(l, t, r, b);
      send_word(ACT_WRITE, SlotW'(s), l, t, r, b, rand_coord(), rand_coord());
      if (s % 4 == 3) random_word();
    end

    run_phase(64, 9999, IDLE_NONE, PhaseWords, 1'b0);
    run_phase(127, -32768, IDLE_SEND, PhaseWords, 1'b0);
    run_phase(1, 32767, IDLE_STALL, PhaseWords, 1'b0);
    run_phase(0, $signed(rand_coord()), IDLE_BOTH, 60, 1'b0);
    run_phase(65, 0, IDLE_NONE, PhaseWords, 1'b1);
    run_phase(2, int'($urandom_range(16)) - 8, IDLE_BOTH, PhaseWords, 1'b0);
    run_phase($urandom_range(3, 20), int'($urandom_range(16)) - 8, IDLE_SEND, PhaseWords, 1'b0);
    run_phase($urandom_range(127), $signed(rand_coord()), IDLE_STALL, PhaseWords, 1'b0);
    run_phase(64, int'($urandom_range(16)) - 8, IDLE_BOTH, PhaseWords, 1'b0);
    run_phase(8, 9999, IDLE_NONE, PhaseWords, 1'b0);

    in_valid <= 1'b0;
    stall_pct <= 0;
    waited = 0;
    @(posedge clk);
    while (pending != 0 && waited < DrainLimit) begin
      waited++;
      @(posedge clk);
    end
    if (pending != 0) begin
      drain_stuck = 1'b1;
      $error("%0d bounds words never arrived", pending);
    end
    repeat (SettleCycles) @(posedge clk);

    $display("Sent %0d words, room writes and queries, over %0d register settings.",
             words_sent, phases);
    $display("Checked %0d bounds words across all idling mixes and one long output hold.",
             checked);
    if (fail_count == 0 && !drain_stuck) begin
      $display("PASS nearest_room_bounds_search_top");
    end else begin
      $display("FAIL nearest_room_bounds_search_top");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("FAIL nearest_room_bounds_search_top");
    $finish;
  end

endmodule
